// ===== rtl/core/fcsg_pkg.sv =====
package fcsg_pkg;

  // Default field widths of the block.
  localparam int unsigned COORD_BITS_DEF  = 16;
  localparam int unsigned RADIUS_BITS_DEF = 12;
  localparam int unsigned COLOR_BITS      = 16;

  // The row limit is radius * 707 / 1000 + 1.
  localparam int unsigned LIMIT_NUM        = 707;
  localparam int unsigned LIMIT_DEN        = 1000;
  // Extra fraction bits of the reciprocal; 2^10 exceeds the divisor, which keeps the
  // rounded-up reciprocal exact for every radius.
  localparam int unsigned LIMIT_GUARD_BITS = 10;

  // A step item gives at most four spans.
  localparam int unsigned JOB_DEPTH    = 4;
  localparam int unsigned JOB_CNT_BITS = 3;

  typedef enum logic {
    MODE_START = 1'b0,
    MODE_STEP  = 1'b1
  } mode_e;

  // Flags that travel with each result.
  typedef struct packed {
    logic done;
    logic last;
    logic valid;
  } span_flags_t;

endpackage

// ===== rtl/core/fcsg_engine.sv =====
module fcsg_engine #(
  parameter int unsigned COORD_BITS  = fcsg_pkg::COORD_BITS_DEF,
  parameter int unsigned RADIUS_BITS = fcsg_pkg::RADIUS_BITS_DEF
) (
  input  logic                                                   clk_i,
  input  logic                                                   rst_ni,
  input  logic                                                   take_i,
  input  fcsg_pkg::mode_e                                        mode_i,
  input  logic [COORD_BITS-1:0]                                  cx_i,
  input  logic [COORD_BITS-1:0]                                  cy_i,
  input  logic [RADIUS_BITS-1:0]                                 radius_i,
  input  logic [fcsg_pkg::COLOR_BITS-1:0]                        color_i,
  output logic [fcsg_pkg::JOB_CNT_BITS-1:0]                      job_cnt_o,
  output logic [fcsg_pkg::JOB_DEPTH-1:0][COORD_BITS-1:0]         job_left_o,
  output logic [fcsg_pkg::JOB_DEPTH-1:0][COORD_BITS-1:0]         job_right_o,
  output logic [fcsg_pkg::JOB_DEPTH-1:0][COORD_BITS-1:0]         job_row_o,
  output fcsg_pkg::span_flags_t [fcsg_pkg::JOB_DEPTH-1:0]        job_flags_o,
  output logic [fcsg_pkg::COLOR_BITS-1:0]                        job_color_o
);

  localparam int unsigned SQ_W   = 2 * RADIUS_BITS;
  localparam int unsigned K      = RADIUS_BITS + fcsg_pkg::LIMIT_GUARD_BITS;
  localparam int unsigned PROD_W = RADIUS_BITS + K;
  localparam int unsigned SW     = (COORD_BITS > RADIUS_BITS) ? COORD_BITS : RADIUS_BITS;
  localparam longint unsigned LIMIT_MUL =
    ((64'(fcsg_pkg::LIMIT_NUM) << K) + 64'(fcsg_pkg::LIMIT_DEN) - 64'd1) /
    64'(fcsg_pkg::LIMIT_DEN);
  localparam logic [K-1:0] LIMIT_MUL_V = K'(LIMIT_MUL);

  // Circle state.
  logic [COORD_BITS-1:0]           centre_col_q, centre_row_q;
  logic [fcsg_pkg::COLOR_BITS-1:0] fill_colour_q;
  logic [RADIUS_BITS-1:0]          run_x_q, step_i_q, step_limit_q;
  logic [SQ_W-1:0]                 square_bound_q, i_sq_q, x_sq_q;
  logic                            active_q;

  logic [PROD_W-1:0]      lim_prod;
  logic [RADIUS_BITS-1:0] start_limit;
  logic [SQ_W-1:0]        r_sq, start_bound;
  logic [SQ_W:0]          sq_sum;
  logic                   over, extra, x_dec, fin;
  logic [RADIUS_BITS-1:0] x_n, i_n, hw;
  logic [SQ_W-1:0]        x_sq_n, i_sq_n;

  function automatic logic [COORD_BITS-1:0] add_c(logic [COORD_BITS-1:0] a,
                                                  logic [RADIUS_BITS-1:0] b);
    logic [SW-1:0] s;
    s = SW'(a) + SW'(b);
    return s[COORD_BITS-1:0];
  endfunction

  function automatic logic [COORD_BITS-1:0] sub_c(logic [COORD_BITS-1:0] a,
                                                  logic [RADIUS_BITS-1:0] b);
    logic [SW-1:0] s;
    s = SW'(a) - SW'(b);
    return s[COORD_BITS-1:0];
  endfunction

  // Start: the limit comes from a multiplication by 707/1000, rounded up to K fraction bits.
  assign lim_prod    = PROD_W'(radius_i) * PROD_W'(LIMIT_MUL_V);
  assign start_limit = lim_prod[PROD_W-1:K] + RADIUS_BITS'(1);
  assign r_sq        = SQ_W'(radius_i) * SQ_W'(radius_i);
  assign start_bound = r_sq + SQ_W'(radius_i >> 1);

  // Step: the squares of i and x are kept up to date incrementally.
  assign sq_sum = {1'b0, i_sq_q} + {1'b0, x_sq_q};
  assign over   = sq_sum > {1'b0, square_bound_q};
  assign extra  = over && (run_x_q > step_limit_q);
  assign x_dec  = over && (run_x_q != '0);
  assign x_n    = run_x_q - RADIUS_BITS'(x_dec);
  assign x_sq_n = x_dec ? (x_sq_q - (SQ_W'(run_x_q) << 1) + SQ_W'(1)) : x_sq_q;
  assign i_n    = step_i_q + RADIUS_BITS'(1);
  assign i_sq_n = i_sq_q + (SQ_W'(step_i_q) << 1) + SQ_W'(1);
  assign hw     = step_i_q - RADIUS_BITS'(1);
  assign fin    = i_n > step_limit_q;

  always_comb begin
    job_cnt_o   = fcsg_pkg::JOB_CNT_BITS'(1);
    job_left_o  = '0;
    job_right_o = '0;
    job_row_o   = '0;
    job_flags_o = '0;
    job_color_o = '0;
    if (mode_i == fcsg_pkg::MODE_START) begin
      job_left_o[0]        = sub_c(cx_i, radius_i);
      job_right_o[0]       = add_c(cx_i, radius_i);
      job_row_o[0]         = cy_i;
      job_flags_o[0].valid = 1'b1;
      job_flags_o[0].last  = 1'b1;
      job_color_o          = color_i;
    end else if (!active_q) begin
      // Idle answer: no span, marked last and done.
      job_flags_o[0].last = 1'b1;
      job_flags_o[0].done = 1'b1;
    end else begin
      job_color_o = fill_colour_q;
      for (int k = 0; k < fcsg_pkg::JOB_DEPTH; k++) begin
        job_flags_o[k].valid = 1'b1;
      end
      if (extra) begin
        job_cnt_o      = fcsg_pkg::JOB_CNT_BITS'(4);
        job_left_o[0]  = sub_c(centre_col_q, hw);
        job_right_o[0] = add_c(centre_col_q, hw);
        job_row_o[0]   = add_c(centre_row_q, run_x_q);
        job_left_o[1]  = sub_c(centre_col_q, hw);
        job_right_o[1] = add_c(centre_col_q, hw);
        job_row_o[1]   = sub_c(centre_row_q, run_x_q);
        job_left_o[2]  = sub_c(centre_col_q, x_n);
        job_right_o[2] = add_c(centre_col_q, x_n);
        job_row_o[2]   = add_c(centre_row_q, step_i_q);
        job_left_o[3]  = sub_c(centre_col_q, x_n);
        job_right_o[3] = add_c(centre_col_q, x_n);
        job_row_o[3]   = sub_c(centre_row_q, step_i_q);
        job_flags_o[3].last = 1'b1;
        job_flags_o[3].done = fin;
      end else begin
        job_cnt_o      = fcsg_pkg::JOB_CNT_BITS'(2);
        job_left_o[0]  = sub_c(centre_col_q, x_n);
        job_right_o[0] = add_c(centre_col_q, x_n);
        job_row_o[0]   = add_c(centre_row_q, step_i_q);
        job_left_o[1]  = sub_c(centre_col_q, x_n);
        job_right_o[1] = add_c(centre_col_q, x_n);
        job_row_o[1]   = sub_c(centre_row_q, step_i_q);
        job_flags_o[1].last = 1'b1;
        job_flags_o[1].done = fin;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
    end else if (take_i) begin
      if (mode_i == fcsg_pkg::MODE_START) begin
        active_q <= 1'b1;
      end else if (active_q && fin) begin
        active_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_i) begin
      if (mode_i == fcsg_pkg::MODE_START) begin
        centre_col_q   <= cx_i;
        centre_row_q   <= cy_i;
        fill_colour_q  <= color_i;
        run_x_q        <= radius_i;
        x_sq_q         <= r_sq;
        step_i_q       <= RADIUS_BITS'(1);
        i_sq_q         <= SQ_W'(1);
        step_limit_q   <= start_limit;
        square_bound_q <= start_bound;
      end else if (active_q) begin
        run_x_q  <= x_n;
        x_sq_q   <= x_sq_n;
        step_i_q <= i_n;
        i_sq_q   <= i_sq_n;
      end
    end
  end

endmodule

// ===== rtl/core/filled_circle_span_generator_core.sv =====
// Filled circle span generator. A start item (tuser = 0) loads the centre, radius and
// colour of a circle and answers with the span of the centre row. Each step item
// (tuser = 1) then answers with two or four spans: the rows centre +/- i, and when the
// outer edge moves inwards while x exceeds the row limit also the rows centre +/- x.
// The result that finishes the circle carries done; a step item while no circle runs
// is answered by one result without a span, marked done. Every answer closes with
// tlast. A single output register delivers one span per cycle while the sink is ready.
// The first result of an item passes the input register, the span buffer and the
// output register. The input register takes the next item while the spans of the
// previous one are still leaving, and the output register holds a result while the
// sink stalls. There is no clearing pass after reset.
module filled_circle_span_generator_core #(
  parameter int unsigned COORD_BITS  = fcsg_pkg::COORD_BITS_DEF,
  parameter int unsigned RADIUS_BITS = fcsg_pkg::RADIUS_BITS_DEF,
  localparam int unsigned IN_W  = 2 * COORD_BITS + RADIUS_BITS + fcsg_pkg::COLOR_BITS,
  localparam int unsigned IN_TW = ((IN_W + 7) / 8) * 8,
  localparam int unsigned OUT_W  = 3 * COORD_BITS + fcsg_pkg::COLOR_BITS,
  localparam int unsigned OUT_TW = ((OUT_W + 7) / 8) * 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  // center_x, center_y, radius, color from the lowest bit up; zero padding above.
  input  logic [IN_TW-1:0]  s_axis_tdata_i,
  // mode
  input  logic [0:0]        s_axis_tuser_i,
  output logic              m_axis_tvalid_o,
  input  logic              m_axis_tready_i,
  // span_left, span_right, span_row, span_color from the lowest bit up.
  output logic [OUT_TW-1:0] m_axis_tdata_o,
  // span_valid, done_res from the lowest bit up.
  output logic [1:0]        m_axis_tuser_o,
  output logic              m_axis_tlast_o
);

  localparam int unsigned CB    = COORD_BITS;
  localparam int unsigned RB    = RADIUS_BITS;
  localparam int unsigned CLR_W = fcsg_pkg::COLOR_BITS;
  localparam int unsigned DEPTH = fcsg_pkg::JOB_DEPTH;
  localparam int unsigned CNT_W = fcsg_pkg::JOB_CNT_BITS;

  // Input register.
  logic                  in_vld_q;
  fcsg_pkg::mode_e       in_mode_q;
  logic [CB-1:0]         in_cx_q, in_cy_q;
  logic [RB-1:0]         in_r_q;
  logic [CLR_W-1:0]      in_color_q;

  // Span buffer holding the results of one item.
  logic [CNT_W-1:0]                   job_cnt_q;
  logic [DEPTH-1:0][CB-1:0]           job_left_q, job_right_q, job_row_q;
  fcsg_pkg::span_flags_t [DEPTH-1:0]  job_flags_q;
  logic [CLR_W-1:0]                   job_color_q;

  // Output register.
  logic                  out_vld_q;
  logic [CB-1:0]         out_left_q, out_right_q, out_row_q;
  logic [CLR_W-1:0]      out_color_q;
  fcsg_pkg::span_flags_t out_flags_q;

  // Results of the engine for the item in the input register.
  logic [CNT_W-1:0]                   eng_cnt;
  logic [DEPTH-1:0][CB-1:0]           eng_left, eng_right, eng_row;
  fcsg_pkg::span_flags_t [DEPTH-1:0]  eng_flags;
  logic [CLR_W-1:0]                   eng_color;

  logic s_acc, pop, take;

  // A span leaves the buffer whenever the output register is free or being emptied;
  // the next item enters the buffer when it is empty or as its last span leaves.
  assign pop   = (job_cnt_q != '0) && (!out_vld_q || m_axis_tready_i);
  assign take  = in_vld_q && ((job_cnt_q == '0) || ((job_cnt_q == CNT_W'(1)) && pop));
  assign s_axis_tready_o = !in_vld_q || take;
  assign s_acc = s_axis_tvalid_i && s_axis_tready_o;

  fcsg_engine #(
    .COORD_BITS (COORD_BITS),
    .RADIUS_BITS(RADIUS_BITS)
  ) u_fcsg_engine (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .take_i     (take),
    .mode_i     (in_mode_q),
    .cx_i       (in_cx_q),
    .cy_i       (in_cy_q),
    .radius_i   (in_r_q),
    .color_i    (in_color_q),
    .job_cnt_o  (eng_cnt),
    .job_left_o (eng_left),
    .job_right_o(eng_right),
    .job_row_o  (eng_row),
    .job_flags_o(eng_flags),
    .job_color_o(eng_color)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      job_cnt_q <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (s_acc) begin
        in_vld_q <= 1'b1;
      end else if (take) begin
        in_vld_q <= 1'b0;
      end
      if (take) begin
        job_cnt_q <= eng_cnt;
      end else if (pop) begin
        job_cnt_q <= job_cnt_q - CNT_W'(1);
      end
      if (pop) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      in_cx_q    <= s_axis_tdata_i[CB-1:0];
      in_cy_q    <= s_axis_tdata_i[2*CB-1:CB];
      in_r_q     <= s_axis_tdata_i[2*CB+RB-1:2*CB];
      in_color_q <= s_axis_tdata_i[IN_W-1:2*CB+RB];
      in_mode_q  <= fcsg_pkg::mode_e'(s_axis_tuser_i[0]);
    end
    if (take) begin
      job_left_q  <= eng_left;
      job_right_q <= eng_right;
      job_row_q   <= eng_row;
      job_flags_q <= eng_flags;
      job_color_q <= eng_color;
    end else if (pop) begin
      for (int k = 0; k < DEPTH - 1; k++) begin
        job_left_q[k]  <= job_left_q[k+1];
        job_right_q[k] <= job_right_q[k+1];
        job_row_q[k]   <= job_row_q[k+1];
        job_flags_q[k] <= job_flags_q[k+1];
      end
    end
    if (pop) begin
      out_left_q  <= job_left_q[0];
      out_right_q <= job_right_q[0];
      out_row_q   <= job_row_q[0];
      out_flags_q <= job_flags_q[0];
      out_color_q <= job_color_q;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = OUT_TW'({out_color_q, out_row_q, out_right_q, out_left_q});
  assign m_axis_tuser_o  = {out_flags_q.done, out_flags_q.valid};
  assign m_axis_tlast_o  = out_flags_q.last;

endmodule

// ===== rtl/core/fcsg_checker.sv =====
module fcsg_checker #(
  parameter int unsigned COORD_BITS  = fcsg_pkg::COORD_BITS_DEF,
  parameter int unsigned RADIUS_BITS = fcsg_pkg::RADIUS_BITS_DEF,
  localparam int unsigned IN_W  = 2 * COORD_BITS + RADIUS_BITS + fcsg_pkg::COLOR_BITS,
  localparam int unsigned IN_TW = ((IN_W + 7) / 8) * 8,
  localparam int unsigned OUT_W  = 3 * COORD_BITS + fcsg_pkg::COLOR_BITS,
  localparam int unsigned OUT_TW = ((OUT_W + 7) / 8) * 8
) (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              s_axis_tvalid_i,
  input logic              s_axis_tready_o,
  input logic [IN_TW-1:0]  s_axis_tdata_i,
  input logic [0:0]        s_axis_tuser_i,
  input logic              m_axis_tvalid_o,
  input logic              m_axis_tready_i,
  input logic [OUT_TW-1:0] m_axis_tdata_o,
  input logic [1:0]        m_axis_tuser_o,
  input logic              m_axis_tlast_o
);

  // A stalled result keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o) && $stable(m_axis_tlast_o))
    else $error("stalled result changed");

  // A stalled result is not withdrawn.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("stalled result withdrawn");

  // A result without a span is the idle answer: all zero, last and done.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o[0] |->
      m_axis_tlast_o && m_axis_tuser_o[1] && (m_axis_tdata_o == '0))
    else $error("result without span is not a clean idle answer");

  // Done only ever closes an answer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[1] |-> m_axis_tlast_o)
    else $error("done on a result that is not last");

  // Nothing is offered straight out of reset.
  assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !m_axis_tvalid_o)
    else $error("result offered straight after reset");

endmodule

bind filled_circle_span_generator_core fcsg_checker #(
  .COORD_BITS (COORD_BITS),
  .RADIUS_BITS(RADIUS_BITS)
) u_fcsg_checker (.*);

// ===== bench/filled_circle_span_generator_core_test.sv =====
`timescale 1ns / 1ps

module filled_circle_span_generator_core_test;

  localparam int unsigned IN_TW      = 64;
  localparam int unsigned OUT_TW     = 64;
  localparam int unsigned HOLD_CYC   = 300;
  localparam int unsigned STALL_MAX  = 4000;
  localparam int unsigned RAND_ITEMS = 255;
  localparam int unsigned PRINT_MAX  = 40;

  // One item waiting to be offered; wait_drain makes the sender hold it back
  // until every span owed so far has been delivered.
  typedef struct {
    fcsg_pkg::mode_e mode;
    logic [15:0]     cx;
    logic [15:0]     cy;
    logic [11:0]     radius;
    logic [15:0]     colour;
    bit              wait_drain;
  } circle_cmd_t;

  typedef struct {
    logic [15:0] left;
    logic [15:0] right;
    logic [15:0] row;
    logic [15:0] colour;
    bit          valid;
    bit          last;
    bit          done;
  } span_t;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid;
  logic              in_ready;
  logic [IN_TW-1:0]  in_data;
  logic [0:0]        in_mode;
  logic              out_valid;
  logic              out_ready;
  logic [OUT_TW-1:0] out_data;
  logic [1:0]        out_flags;
  logic              out_last;

  circle_cmd_t cmd_q[$];
  span_t       span_q[$];

  // Shadow of the block's circle state.
  logic [15:0] sh_col    = '0;
  logic [15:0] sh_row    = '0;
  logic [15:0] sh_colour = '0;
  int unsigned sh_x      = 0;
  int unsigned sh_i      = 0;
  int unsigned sh_limit  = 0;
  int unsigned sh_bound  = 0;
  bit          sh_active = 1'b0;

  int unsigned spans_owed    = 0;
  int unsigned items_in      = 0;
  int unsigned starts_in     = 0;
  int unsigned steps_in      = 0;
  int unsigned spans_seen    = 0;
  int unsigned idle_seen     = 0;
  int unsigned mismatches    = 0;
  int unsigned stall_cycles  = 0;
  int unsigned widest_radius = 0;
  bit          sink_hold;
  bit          drain_next;
  bit          no_gaps;

  filled_circle_span_generator_core i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (in_valid),
    .s_axis_tready_o (in_ready),
    .s_axis_tdata_i  (in_data),
    .s_axis_tuser_i  (in_mode),
    .m_axis_tvalid_o (out_valid),
    .m_axis_tready_i (out_ready),
    .m_axis_tdata_o  (out_data),
    .m_axis_tuser_o  (out_flags),
    .m_axis_tlast_o  (out_last)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // A stretch of items in the middle of the run goes through with no gaps.
  assign no_gaps = (items_in >= 180) && (items_in < 230);

  task automatic report_error(string msg);
    mismatches++;
    if (mismatches <= PRINT_MAX) begin
      $display("[%0t] ERROR: %s", $realtime, msg);
    end
  endtask

  function automatic void owe_span(logic [15:0] left, logic [15:0] right, logic [15:0] row);
    span_t s;
    s.left   = left;
    s.right  = right;
    s.row    = row;
    s.colour = sh_colour;
    s.valid  = 1'b1;
    s.last   = 1'b0;
    s.done   = 1'b0;
    span_q.push_back(s);
  endfunction

  // Works out the spans that one accepted item causes; returns how many.
  function automatic int unsigned rasterise_item(fcsg_pkg::mode_e mode, logic [15:0] cx,
                                                 logic [15:0] cy, logic [11:0] radius,
                                                 logic [15:0] colour);
    int unsigned r;
    int unsigned x;
    int unsigned i;
    int unsigned hw;
    int unsigned n;
    span_t       s;
    n = 0;
    if (mode == fcsg_pkg::MODE_START) begin
      r         = 32'(radius);
      sh_col    = cx;
      sh_row    = cy;
      sh_colour = colour;
      sh_limit  = r * fcsg_pkg::LIMIT_NUM / fcsg_pkg::LIMIT_DEN + 1;
      sh_bound  = r * r + r / 2;
      sh_x      = r;
      sh_i      = 1;
      sh_active = 1'b1;
      owe_span(16'(sh_col - r), 16'(sh_col + r), sh_row);
      n = 1;
    end else if (!sh_active) begin
      s = '{left: '0, right: '0, row: '0, colour: '0, valid: 1'b0, last: 1'b1, done: 1'b1};
      span_q.push_back(s);
      return 1;
    end else begin
      i = sh_i;
      x = sh_x;
      if (i * i + x * x > sh_bound) begin
        // The outer edge moves inwards: close off the rows at centre +/- x first.
        if (x > sh_limit) begin
          hw = i - 1;
          owe_span(16'(sh_col - hw), 16'(sh_col + hw), 16'(sh_row + x));
          owe_span(16'(sh_col - hw), 16'(sh_col + hw), 16'(sh_row - x));
          n += 2;
        end
        if (x > 0) begin
          x--;
        end
      end
      owe_span(16'(sh_col - x), 16'(sh_col + x), 16'(sh_row + i));
      owe_span(16'(sh_col - x), 16'(sh_col + x), 16'(sh_row - i));
      n += 2;
      sh_x = x;
      sh_i = i + 1;
      if (sh_i > sh_limit) begin
        sh_active = 1'b0;
        span_q[span_q.size()-1].done = 1'b1;
      end
    end
    span_q[span_q.size()-1].last = 1'b1;
    return n;
  endfunction

  function automatic void add_cmd(fcsg_pkg::mode_e mode, logic [15:0] cx, logic [15:0] cy,
                                  logic [11:0] radius, logic [15:0] colour);
    circle_cmd_t c;
    c.mode       = mode;
    c.cx         = cx;
    c.cy         = cy;
    c.radius     = radius;
    c.colour     = colour;
    c.wait_drain = drain_next;
    drain_next   = 1'b0;
    cmd_q.push_back(c);
  endfunction

  // Steps carry random content in the fields, which the block must ignore.
  function automatic void add_steps(int unsigned count);
    repeat (count) begin
      add_cmd(fcsg_pkg::MODE_STEP, 16'($urandom), 16'($urandom), 12'($urandom),
              16'($urandom));
    end
  endfunction

  function automatic int unsigned rows_of(int unsigned r);
    return r * fcsg_pkg::LIMIT_NUM / fcsg_pkg::LIMIT_DEN + 1;
  endfunction

  // Sender: presents the queued items in order, with random gaps.
  always @(posedge clk_i or negedge rst_ni) begin : drive_items
    circle_cmd_t nxt;
    bit          gap;
    bit          busy;
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_data  <= '0;
      in_mode  <= fcsg_pkg::MODE_START;
    end else if (!in_valid || in_ready) begin
      gap  = !no_gaps && ($urandom_range(0, 99) < 9);
      busy = (in_valid && in_ready) || (spans_owed != 0);
      if (cmd_q.size() != 0 && !gap && !(cmd_q[0].wait_drain && busy)) begin
        nxt      = cmd_q.pop_front();
        in_valid <= 1'b1;
        in_data  <= {4'b0, nxt.colour, nxt.radius, nxt.cy, nxt.cx};
        in_mode  <= nxt.mode;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random back-pressure, plus one long hold-off.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= !sink_hold && (no_gaps || ($urandom_range(0, 99) >= 9));
    end
  end

  // Monitor: predicts on each accepted item and checks each accepted result.
  always @(posedge clk_i) begin : observe
    span_t       want;
    int unsigned added;
    int unsigned taken;
    if (rst_ni) begin
      added = 0;
      taken = 0;
      if (out_valid && out_ready) begin
        if (span_q.size() == 0) begin
          report_error($sformatf("result with nothing expected, data %h", out_data));
        end else begin
          taken = 1;
          want = span_q.pop_front();
          if (out_data[15:0] !== want.left) begin
            report_error($sformatf("span_left %h, expected %h", out_data[15:0], want.left));
          end
          if (out_data[31:16] !== want.right) begin
            report_error($sformatf("span_right %h, expected %h", out_data[31:16], want.right));
          end
          if (out_data[47:32] !== want.row) begin
            report_error($sformatf("span_row %h, expected %h", out_data[47:32], want.row));
          end
          if (out_data[63:48] !== want.colour) begin
            report_error($sformatf("span_color %h, expected %h", out_data[63:48], want.colour));
          end
          if (out_flags[0] !== want.valid) begin
            report_error($sformatf("span_valid %b, expected %b", out_flags[0], want.valid));
          end
          if (out_flags[1] !== want.done) begin
            report_error($sformatf("done %b, expected %b", out_flags[1], want.done));
          end
          if (out_last !== want.last) begin
            report_error($sformatf("tlast %b, expected %b", out_last, want.last));
          end
          if (want.valid) begin
            spans_seen++;
          end else begin
            idle_seen++;
          end
        end
      end
      if (in_valid && in_ready) begin
        added = rasterise_item(fcsg_pkg::mode_e'(in_mode), in_data[15:0], in_data[31:16],
                               in_data[43:32], in_data[59:44]);
        if (in_mode == fcsg_pkg::MODE_START) begin
          starts_in++;
          if (in_data[43:32] > widest_radius) begin
            widest_radius = 32'(in_data[43:32]);
          end
        end else begin
          steps_in++;
        end
        items_in <= items_in + 1;
      end
      spans_owed <= spans_owed + added - taken;
    end
  end

  // Watchdog: ends the run when nothing moves on either side for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_MAX) begin
        $display("timeout: no item moved for %0d cycles", STALL_MAX);
        $display("DONE: errors detected");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  // Long hold-off of the receiver so that the block fills up and stalls its input.
  initial begin
    sink_hold = 1'b0;
    wait (items_in >= 60);
    @(posedge clk_i);
    sink_hold <= 1'b1;
    repeat (HOLD_CYC) @(posedge clk_i);
    sink_hold <= 1'b0;
  end

  initial begin : run
    int unsigned rand_items;
    int unsigned pick;
    int unsigned r;
    int unsigned n_steps;
    int unsigned before_n;
    rst_ni     = 1'b0;
    drain_next = 1'b0;

    // Directed part: a step straight after reset finds the block idle.
    add_steps(1);
    // Zero radius at the origin: the row at centre - i wraps, x saturates at zero.
    add_cmd(fcsg_pkg::MODE_START, 16'h0000, 16'h0000, 12'd0, 16'hFFFF);
    add_steps(2);
    // Largest radius at the top corner, dropped after a few steps.
    add_cmd(fcsg_pkg::MODE_START, 16'hFFFF, 16'hFFFF, 12'hFFF, 16'h0000);
    add_steps(3);
    // Start while active replaces the running circle.
    add_cmd(fcsg_pkg::MODE_START, 16'h8000, 16'h7FFF, 12'd1, 16'hA5A5);
    add_steps(2);
    add_cmd(fcsg_pkg::MODE_START, 16'h0003, 16'hFFFE, 12'd5, 16'h5A5A);
    add_steps(rows_of(5) + 1);
    // The sender waits for a full drain before this circle.
    drain_next = 1'b1;
    add_cmd(fcsg_pkg::MODE_START, 16'd100, 16'd100, 12'd7, 16'h0F0F);
    add_steps(rows_of(7));

    // Random part: mostly complete circles, some cut short, some stray steps.
    rand_items = 0;
    while (rand_items < RAND_ITEMS) begin
      before_n = cmd_q.size();
      pick     = $urandom_range(0, 99);
      if (rand_items >= 120 && rand_items < 135) begin
        drain_next = 1'b1;
      end
      if (pick < 70) begin
        if ($urandom_range(0, 9) == 0) begin
          r       = $urandom_range(0, 4095);
          n_steps = $urandom_range(1, 6);
        end else begin
          r       = $urandom_range(0, 24);
          n_steps = rows_of(r) + (($urandom_range(0, 3) == 0) ? 1 : 0);
        end
        add_cmd(fcsg_pkg::MODE_START, 16'($urandom), 16'($urandom), 12'(r), 16'($urandom));
        add_steps(n_steps);
      end else if (pick < 85) begin
        r = $urandom_range(0, 24);
        add_cmd(fcsg_pkg::MODE_START, 16'($urandom), 16'($urandom), 12'(r), 16'($urandom));
        add_steps($urandom_range(0, rows_of(r) - 1));
      end else begin
        add_steps($urandom_range(1, 3));
      end
      rand_items += cmd_q.size() - before_n;
    end

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (cmd_q.size() != 0 || in_valid || spans_owed != 0) begin
      @(posedge clk_i);
    end
    // Let any stray result that follows the last expected one show up.
    repeat (12) @(posedge clk_i);
    if (span_q.size() != 0) begin
      report_error($sformatf("%0d results never arrived", span_q.size()));
    end

    $display("Ran %0d items (%0d circle starts, %0d row steps), radius up to %0d.",
             items_in, starts_in, steps_in, widest_radius);
    $display("Checked %0d spans and %0d idle answers, with one %0d-cycle sink hold-off.",
             spans_seen, idle_seen, HOLD_CYC);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
